FILE: design/iee_pkg.sv
// Package for the infix expression evaluator: item types, character codes,
// status codes and the operator precedence function. No dependencies.
`timescale 1ns / 1ps
package iee_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} result_item_t;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_OVERFLOW  = 3'd1;
	localparam status_t ST_UNDERFLOW = 3'd2;
	localparam status_t ST_DIVZERO   = 3'd3;
	localparam status_t ST_UNKNOWN   = 3'd4;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Precedence of an operator character; zero for anything else.
	function automatic logic [1:0] op_rank(input logic [7:0] c);
		logic [1:0] r;
		r = 2'd0;
		if (c == CH_PLUS || c == CH_MINUS) begin
			r = 2'd1;
		end else if (c == CH_MUL || c == CH_DIV) begin
			r = 2'd2;
		end
		return r;
	endfunction

endpackage

FILE: design/infix_expression_evaluator_core.sv
// Infix expression evaluator top level: sequencer, stacks and shared ALU.
// Depends on iee_pkg and iee_ram.
// A digit updates the accumulator and checks for the last character; any other
// character flushes a pending number and is dispatched. Each reduced operator pops
// two operands, executes and pushes its result; a division runs the restoring
// divider. The last character adds the final reductions and any wait for the output register.
// One item is processed at a time.
// Reset clears counts, accumulator, status and handshake state; stacks are not cleared.
`timescale 1ns / 1ps
module infix_expression_evaluator_core #(
	parameter int STACK_DEPTH = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  iee_pkg::char_item_t   char_item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output iee_pkg::result_item_t result_item
);
	import iee_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	typedef enum logic [16:0] {
		S_IDLE     = 17'h00001,
		S_CHKLAST  = 17'h00002,
		S_FLUSH    = 17'h00004,
		S_DISPATCH = 17'h00008,
		S_OPPUSH   = 17'h00010,
		S_LOOP     = 17'h00020,
		S_OPTOP    = 17'h00040,
		S_POPB     = 17'h00080,
		S_GETB     = 17'h00100,
		S_POPA     = 17'h00200,
		S_GETA     = 17'h00400,
		S_EXEC     = 17'h00800,
		S_DIV      = 17'h01000,
		S_NPUSH    = 17'h02000,
		S_FPOP     = 17'h04000,
		S_FGET     = 17'h08000,
		S_EMIT     = 17'h10000
	} state_t;

	typedef enum logic [1:0] {
		M_CLOSE = 2'd0,
		M_OPER  = 2'd1,
		M_FINAL = 2'd2
	} mode_t;

	state_t        state_q;
	mode_t         mode_q;
	logic [7:0]    ch_q;
	logic          last_q;
	logic          final_q;
	logic [CW-1:0] ncnt_q;
	logic [CW-1:0] ocnt_q;
	logic [31:0]   acc_q;
	logic          innum_q;
	status_t       sticky_q;
	logic [7:0]    op_q;
	logic [31:0]   a_q;
	logic [31:0]   b_q;
	logic [31:0]   r_q;
	logic [31:0]   value_q;
	logic [31:0]   rem_q;
	logic [31:0]   dq_q;
	logic          dneg_q;
	logic [5:0]    dcnt_q;
	logic          res_valid_q;
	result_item_t  res_q;

	logic          n_we;
	logic [AW-1:0] n_waddr;
	logic [31:0]   n_wdata;
	logic [31:0]   n_rdata;
	logic          o_we;
	logic [AW-1:0] o_waddr;
	logic [7:0]    o_wdata;
	logic [7:0]    o_rdata;
	logic [CW-1:0] ncnt_m1;
	logic [CW-1:0] ocnt_m1;

	logic [32:0] rem_sh;
	logic [32:0] rem_diff;
	logic        is_digit;
	logic        take;
	logic        emit_go;

	assign ncnt_m1 = ncnt_q - 1'b1;
	assign ocnt_m1 = ocnt_q - 1'b1;

	iee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_num_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (ncnt_m1[AW-1:0]),
		.rdata (n_rdata)
	);

	iee_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_op_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (ocnt_m1[AW-1:0]),
		.rdata (o_rdata)
	);

	// Stack write ports: number pushes from flush and reduce, operator pushes.
	always_comb begin
		n_we    = 1'b0;
		n_wdata = r_q;
		if (state_q == S_FLUSH) begin
			n_we    = innum_q && (ncnt_q != FULL);
			n_wdata = acc_q;
		end else if (state_q == S_NPUSH) begin
			n_we = (ncnt_q != FULL);
		end
		n_waddr = ncnt_q[AW-1:0];
		o_we    = (state_q == S_OPPUSH) && (ocnt_q != FULL);
		o_waddr = ocnt_q[AW-1:0];
		o_wdata = ch_q;
	end

	// One restoring division step.
	assign rem_sh   = {rem_q, dq_q[31]};
	assign rem_diff = rem_sh - {1'b0, b_q};

	assign is_digit   = (char_item.ch >= CH_ZERO) && (char_item.ch <= CH_NINE);
	assign char_stall = (state_q != S_IDLE);
	assign take       = char_valid && !char_stall;

	// The emit state may load the output register once it is free or leaving.
	assign emit_go = (state_q == S_EMIT) && (!res_valid_q || !result_stall);

	assign result_valid = res_valid_q;
	assign result_item  = res_q;

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_CLOSE;
			final_q     <= 1'b0;
			ncnt_q      <= '0;
			ocnt_q      <= '0;
			acc_q       <= '0;
			innum_q     <= 1'b0;
			sticky_q    <= ST_OK;
			dcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						ch_q    <= char_item.ch;
						last_q  <= char_item.last;
						final_q <= 1'b0;
						if (is_digit) begin
							acc_q   <= 32'(acc_q * 32'd10) + 32'(char_item.ch - CH_ZERO);
							innum_q <= 1'b1;
							state_q <= S_CHKLAST;
						end else begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_CHKLAST: begin
					if (last_q) begin
						final_q <= 1'b1;
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					// Push a pending number.
					if (innum_q) begin
						if (ncnt_q == FULL) begin
							if (sticky_q == ST_OK) sticky_q <= ST_OVERFLOW;
						end else begin
							ncnt_q <= ncnt_q + 1'b1;
						end
						acc_q   <= '0;
						innum_q <= 1'b0;
					end
					if (final_q) begin
						mode_q  <= M_FINAL;
						state_q <= S_LOOP;
					end else begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (ch_q == CH_SPACE) begin
						state_q <= S_CHKLAST;
					end else if (ch_q == CH_OPEN) begin
						state_q <= S_OPPUSH;
					end else if (ch_q == CH_CLOSE) begin
						mode_q  <= M_CLOSE;
						state_q <= S_LOOP;
					end else if (op_rank(ch_q) != 2'd0) begin
						mode_q  <= M_OPER;
						state_q <= S_LOOP;
					end else begin
						if (sticky_q == ST_OK) sticky_q <= ST_UNKNOWN;
						state_q <= S_CHKLAST;
					end
				end
				S_OPPUSH: begin
					if (ocnt_q == FULL) begin
						if (sticky_q == ST_OK) sticky_q <= ST_OVERFLOW;
					end else begin
						ocnt_q <= ocnt_q + 1'b1;
					end
					state_q <= S_CHKLAST;
				end
				S_LOOP: begin
					// The operator RAM reads the top entry during this cycle.
					if (ocnt_q != '0) begin
						state_q <= S_OPTOP;
					end else begin
						case (mode_q)
							M_CLOSE: begin
								if (sticky_q == ST_OK) sticky_q <= ST_UNDERFLOW;
								state_q <= S_CHKLAST;
							end
							M_OPER: state_q <= S_OPPUSH;
							default: state_q <= S_FPOP;
						endcase
					end
				end
				S_OPTOP: begin
					op_q <= o_rdata;
					if (mode_q == M_CLOSE && o_rdata == CH_OPEN) begin
						ocnt_q  <= ocnt_m1;
						state_q <= S_CHKLAST;
					end else if (mode_q == M_OPER && op_rank(o_rdata) < op_rank(ch_q)) begin
						state_q <= S_OPPUSH;
					end else begin
						ocnt_q <= ocnt_m1;
						if (op_rank(o_rdata) == 2'd0) begin
							state_q <= S_LOOP;
						end else begin
							state_q <= S_POPB;
						end
					end
				end
				S_POPB: begin
					if (ncnt_q == '0) begin
						if (sticky_q == ST_OK) sticky_q <= ST_UNDERFLOW;
						b_q     <= '1;
						state_q <= S_POPA;
					end else begin
						ncnt_q  <= ncnt_m1;
						state_q <= S_GETB;
					end
				end
				S_GETB: begin
					b_q     <= n_rdata;
					state_q <= S_POPA;
				end
				S_POPA: begin
					if (ncnt_q == '0) begin
						if (sticky_q == ST_OK) sticky_q <= ST_UNDERFLOW;
						a_q     <= '1;
						state_q <= S_EXEC;
					end else begin
						ncnt_q  <= ncnt_m1;
						state_q <= S_GETA;
					end
				end
				S_GETA: begin
					a_q     <= n_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_NPUSH;
					if (op_q == CH_PLUS) begin
						r_q <= a_q + b_q;
					end else if (op_q == CH_MINUS) begin
						r_q <= a_q - b_q;
					end else if (op_q == CH_MUL) begin
						r_q <= 32'(a_q * b_q);
					end else if (b_q == '0) begin
						if (sticky_q == ST_OK) sticky_q <= ST_DIVZERO;
						r_q <= '0;
					end else begin
						// Divide magnitudes; the divisor magnitude replaces b.
						rem_q   <= '0;
						dq_q    <= a_q[31] ? (32'd0 - a_q) : a_q;
						b_q     <= b_q[31] ? (32'd0 - b_q) : b_q;
						dneg_q  <= a_q[31] ^ b_q[31];
						dcnt_q  <= 6'd32;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q == '0) begin
						r_q     <= dneg_q ? (32'd0 - dq_q) : dq_q;
						state_q <= S_NPUSH;
					end else begin
						if (!rem_diff[32]) begin
							rem_q <= rem_diff[31:0];
							dq_q  <= {dq_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh[31:0];
							dq_q  <= {dq_q[30:0], 1'b0};
						end
						dcnt_q <= dcnt_q - 1'b1;
					end
				end
				S_NPUSH: begin
					if (ncnt_q == FULL) begin
						if (sticky_q == ST_OK) sticky_q <= ST_OVERFLOW;
					end else begin
						ncnt_q <= ncnt_q + 1'b1;
					end
					state_q <= S_LOOP;
				end
				S_FPOP: begin
					if (ncnt_q == '0) begin
						if (sticky_q == ST_OK) sticky_q <= ST_UNDERFLOW;
						value_q <= '1;
						state_q <= S_EMIT;
					end else begin
						ncnt_q  <= ncnt_m1;
						state_q <= S_FGET;
					end
				end
				S_FGET: begin
					value_q <= n_rdata;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// Hand the result to the output register and start afresh.
					if (emit_go) begin
						res_q.value  <= value_q;
						res_q.status <= sticky_q;
						ncnt_q       <= '0;
						ocnt_q       <= '0;
						acc_q        <= '0;
						innum_q      <= 1'b0;
						sticky_q     <= ST_OK;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The stack counts never pass the depth.
	a_ncnt: assert property (@(posedge clk) disable iff (!arst_n) ncnt_q <= FULL)
		else $error("number stack count beyond depth");
	a_ocnt: assert property (@(posedge clk) disable iff (!arst_n) ocnt_q <= FULL)
		else $error("operator stack count beyond depth");

	// A new result appears only out of the emit state.
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_EMIT))
		else $error("result without emit");

	// The divider counter runs only inside the divide state.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		(dcnt_q != '0) |-> (state_q == S_DIV))
		else $error("divider active outside divide state");

endmodule

FILE: design/iee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module iee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
